// File: sv/mexp_pkg.sv
`timescale 1ns / 1ps

package mexp_pkg;

    // Modulus bits that take part in the arithmetic (8 .. 31).
    localparam int MOD_BITS = 31;
    // Exponent bits that take part in the scan (8 .. 63).
    localparam int EXP_BITS = 63;

    // Fixed port widths.
    localparam int BASE_W = 63;
    localparam int EXPIN_W = 63;
    localparam int MODIN_W = 31;
    localparam int RES_W = 31;

    // One shared down counter covers the base reduction and the multiply steps.
    localparam int CNT_W = $clog2(BASE_W);

    typedef struct packed {
        logic load;      // capture a new word
        logic red_step;  // one bit of base mod m
        logic mul_init;  // start a pair of modular multiplies
        logic mul_step;  // one bit of both multiplies
        logic exp_step;  // commit products, shift exponent
        logic out_load;  // write the output register
    } t_cmd;

    typedef struct packed {
        logic m_small;   // modulus is 0 or 1
        logic e_zero;    // no exponent bits left
        logic out_free;  // output register can take a word
    } t_sts;

    // r*2 + (b ? x : 0) mod m, with r < m and x < m.
    function automatic logic [MOD_BITS-1:0] dbl_add_mod(
        input logic [MOD_BITS-1:0] r,
        input logic [MOD_BITS-1:0] x,
        input logic [MOD_BITS-1:0] m,
        input logic                b
    );
        logic [MOD_BITS:0] t;
        logic [MOD_BITS:0] mm;
        mm = {1'b0, m};
        t = {r, 1'b0};
        if (t >= mm) begin
            t = t - mm;
        end
        if (b) begin
            t = t + {1'b0, x};
        end
        if (t >= mm) begin
            t = t - mm;
        end
        return t[MOD_BITS-1:0];
    endfunction

endpackage

// File: sv/mexp_ctrl.sv
`timescale 1ns / 1ps

module mexp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  mexp_pkg::t_sts    i_sts,
    output mexp_pkg::t_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_REDUCE = 3'd1;
    localparam logic [2:0] S_ESTART = 3'd2;
    localparam logic [2:0] S_MUL    = 3'd3;
    localparam logic [2:0] S_EXP    = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    localparam int CW = mexp_pkg::CNT_W;

    logic [2:0]    r_state;
    logic [2:0]    n_state;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt = CW'(mexp_pkg::BASE_W - 1);
                    n_state = S_REDUCE;
                end
            end
            S_REDUCE: begin
                o_cmd.red_step = 1'b1;
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    n_state = S_ESTART;
                end
            end
            S_ESTART: begin
                if (i_sts.m_small || i_sts.e_zero) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.mul_init = 1'b1;
                    n_cnt = CW'(mexp_pkg::MOD_BITS - 1);
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    n_state = S_EXP;
                end
            end
            S_EXP: begin
                o_cmd.exp_step = 1'b1;
                n_state = S_ESTART;
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= '0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// File: sv/mexp_dpath.sv
`timescale 1ns / 1ps

module mexp_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_action,
    input  logic [mexp_pkg::BASE_W-1:0]   i_base,
    input  logic [mexp_pkg::EXPIN_W-1:0]  i_exponent,
    input  logic [mexp_pkg::MODIN_W-1:0]  i_modulus,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic [mexp_pkg::RES_W-1:0]    o_result,
    input  mexp_pkg::t_cmd                i_cmd,
    output mexp_pkg::t_sts                o_sts
);

    localparam int MW = mexp_pkg::MOD_BITS;
    localparam int EW = mexp_pkg::EXP_BITS;
    localparam int BW = mexp_pkg::BASE_W;
    localparam int RW = mexp_pkg::RES_W;

    logic [MW-1:0] r_m;
    logic [BW-1:0] r_base;
    logic [EW-1:0] r_e;
    logic [MW-1:0] r_acc;
    logic [MW-1:0] r_sq;
    logic [MW-1:0] r_pa;
    logic [MW-1:0] r_ps;
    logic [MW-1:0] r_y;
    logic          r_out_valid;
    logic [RW-1:0] r_result;

    logic [MW-1:0] mod_in;
    logic [EW-1:0] e_start;
    logic [MW:0]   red_t;
    logic [MW-1:0] red_next;
    logic          m_small;

    assign mod_in = i_modulus[MW-1:0];
    // The inverse uses Fermat's exponent m - 2.
    assign e_start = i_action ? EW'(mod_in - MW'(2)) : i_exponent[EW-1:0];

    // One restoring step of base mod m, base fed in from its top bit.
    assign red_t = {r_sq, r_base[BW-1]};
    assign red_next = (red_t >= {1'b0, r_m}) ? MW'(red_t - {1'b0, r_m}) : red_t[MW-1:0];

    assign m_small = (r_m[MW-1:1] == '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_m <= mod_in;
            r_base <= i_base;
            r_e <= e_start;
            r_acc <= MW'(1);
            r_sq <= '0;
        end
        if (i_cmd.red_step) begin
            r_sq <= red_next;
            r_base <= r_base << 1;
        end
        if (i_cmd.mul_init) begin
            r_y <= r_sq;
            r_pa <= '0;
            r_ps <= '0;
        end
        // Both products share the multiplier bits of the running square.
        if (i_cmd.mul_step) begin
            r_pa <= mexp_pkg::dbl_add_mod(r_pa, r_acc, r_m, r_y[MW-1]);
            r_ps <= mexp_pkg::dbl_add_mod(r_ps, r_sq, r_m, r_y[MW-1]);
            r_y <= r_y << 1;
        end
        if (i_cmd.exp_step) begin
            if (r_e[0]) begin
                r_acc <= r_pa;
            end
            r_sq <= r_ps;
            r_e <= r_e >> 1;
        end
        if (i_cmd.out_load) begin
            r_result <= m_small ? '0 : RW'(r_acc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.m_small = m_small;
    assign o_sts.e_zero = (r_e == '0);
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_result = r_result;

endmodule

// File: sv/modular_exponentiation_unit.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake                 Payload
// in       input      i_in_valid / o_in_stall   i_action, i_base, i_exponent, i_modulus
// out      output     o_out_valid / i_out_stall o_result
//
// One word at a time: the word is taken and the base is reduced bit by bit, then, unless
// the modulus is 0 or 1, each exponent bit up to the highest set one runs a multiply pass,
// both modular products running bit-serially side by side; a last exponent check and the
// output write, which waits for the output register to be free, close the word.
// Reset (i_rst_n low at a clock edge) empties the output register and idles the controller.
// A finished word waits in the output register under i_out_stall while a new word is taken.

module modular_exponentiation_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_action,
    input  logic [mexp_pkg::BASE_W-1:0]   i_base,
    input  logic [mexp_pkg::EXPIN_W-1:0]  i_exponent,
    input  logic [mexp_pkg::MODIN_W-1:0]  i_modulus,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [mexp_pkg::RES_W-1:0]    o_result
);

    mexp_pkg::t_cmd cmd;
    mexp_pkg::t_sts sts;

    mexp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mexp_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_action    (i_action),
        .i_base      (i_base),
        .i_exponent  (i_exponent),
        .i_modulus   (i_modulus),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_result    (o_result),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

// File: sv/mexp_checker.sv
`timescale 1ns / 1ps

module mexp_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          i_action,
    input logic [mexp_pkg::BASE_W-1:0]   i_base,
    input logic [mexp_pkg::EXPIN_W-1:0]  i_exponent,
    input logic [mexp_pkg::MODIN_W-1:0]  i_modulus,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [mexp_pkg::RES_W-1:0]    o_result
);

    // A waiting result word holds until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_result))
        else $error("output word changed while stalled");

    // An accepted word keeps the block busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after a word was taken");

    // A new result only appears as a busy period ends.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall) && !o_in_stall)
        else $error("result appeared without a finished word");

    // Reset leaves no result pending.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind modular_exponentiation_unit mexp_checker u_mexp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_action    (i_action),
    .i_base      (i_base),
    .i_exponent  (i_exponent),
    .i_modulus   (i_modulus),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_result    (o_result)
);

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam logic ACT_POWER   = 1'b0;
    localparam logic ACT_INVERSE = 1'b1;

    localparam int MAX_GAP       = 13;
    localparam int DRAIN_CYCLES  = 2300;
    localparam int LONG_HOLD     = 6000;

    typedef struct {
        int unsigned                 seq;
        logic [mexp_pkg::RES_W-1:0]  power;
    } t_pending;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_stall;
    logic                           i_action = ACT_POWER;
    logic [mexp_pkg::BASE_W-1:0]    i_base = '0;
    logic [mexp_pkg::EXPIN_W-1:0]   i_exponent = '0;
    logic [mexp_pkg::MODIN_W-1:0]   i_modulus = '0;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    logic [mexp_pkg::RES_W-1:0]     o_result;

    t_pending     pending_powers[$];
    int unsigned  mismatch_count = 0;
    int unsigned  words_sent = 0;
    int unsigned  hold_request = 0;
    bit           idle_enable = 1'b1;
    int unsigned  primes[8] = '{2, 3, 5, 7, 65537, 998244353, 1000000007, 2147483647};

    modular_exponentiation_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_action),
        .i_base      (i_base),
        .i_exponent  (i_exponent),
        .i_modulus   (i_modulus),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (o_result)
    );

    always #5 i_clk = ~i_clk;

    // Right-to-left square-and-multiply on 64-bit integers; operands stay below 2^31,
    // so every product fits.
    function automatic logic [mexp_pkg::RES_W-1:0] modexp_predict(
        input logic                         act,
        input logic [mexp_pkg::BASE_W-1:0]  b,
        input logic [mexp_pkg::EXPIN_W-1:0] e_in,
        input logic [mexp_pkg::MODIN_W-1:0] m_in
    );
        logic [63:0]                  m;
        logic [63:0]                  acc;
        logic [63:0]                  sq;
        logic [mexp_pkg::EXPIN_W-1:0] e;
        m = {33'd0, m_in} & ((64'd1 << mexp_pkg::MOD_BITS) - 64'd1);
        if (m < 64'd2) begin
            return '0;
        end
        if (act == ACT_INVERSE) begin
            e = mexp_pkg::EXPIN_W'(m - 64'd2);
        end else begin
            e = e_in;
        end
        acc = 64'd1;
        sq = {1'b0, b} % m;
        for (int i = 0; i < mexp_pkg::EXP_BITS; i++) begin
            if (e[i]) begin
                acc = (acc * sq) % m;
            end
            sq = (sq * sq) % m;
        end
        return acc[mexp_pkg::RES_W-1:0];
    endfunction

    function automatic logic [62:0] rand_wide();
        return 63'({$urandom, $urandom});
    endfunction

    task automatic report_mismatch(input string what, input int unsigned seq,
                                   input logic [mexp_pkg::RES_W-1:0] got,
                                   input logic [mexp_pkg::RES_W-1:0] want);
        mismatch_count++;
        $display("[%0t] MISMATCH word %0d %s: got %0d, expected %0d",
                 $time, seq, what, got, want);
    endtask

    task automatic send_word(input logic act, input logic [mexp_pkg::BASE_W-1:0] b,
                             input logic [mexp_pkg::EXPIN_W-1:0] e,
                             input logic [mexp_pkg::MODIN_W-1:0] m);
        int unsigned gap;
        t_pending    entry;
        gap = idle_enable ? $urandom_range(0, MAX_GAP) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action <= act;
        i_base <= b;
        i_exponent <= e;
        i_modulus <= m;
        do @(posedge i_clk); while (o_in_stall);
        entry.seq = words_sent;
        entry.power = modexp_predict(act, b, e, m);
        pending_powers = {pending_powers, entry};
        words_sent++;
    endtask

    // Drops the input valid so that the last word is not taken a second time.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_powers.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_random_word();
        logic [mexp_pkg::MODIN_W-1:0] m;
        logic [mexp_pkg::BASE_W-1:0]  b;
        logic [mexp_pkg::EXPIN_W-1:0] e;
        case ($urandom_range(0, 9))
            0: m = mexp_pkg::MODIN_W'($urandom_range(0, 3));
            1, 2: m = mexp_pkg::MODIN_W'(primes[$urandom_range(0, 7)]);
            3: m = mexp_pkg::MODIN_W'($urandom_range(2, 255));
            default: m = mexp_pkg::MODIN_W'($urandom);
        endcase
        case ($urandom_range(0, 7))
            0: b = '0;
            1: b = mexp_pkg::BASE_W'($urandom_range(0, 1000));
            2: b = mexp_pkg::BASE_W'(64'(m) * $urandom_range(1, 1000));
            3: b = '1;
            default: b = rand_wide();
        endcase
        // Shorter exponents keep the run time down and vary the latency.
        case ($urandom_range(0, 7))
            0: e = mexp_pkg::EXPIN_W'($urandom_range(0, 20));
            1, 2, 3: e = rand_wide() >> $urandom_range(0, 62);
            4: e = '1;
            default: e = rand_wide();
        endcase
        send_word(1'($urandom_range(0, 1)), b, e, m);
    endtask

    task automatic test_directed_cases();
        send_word(ACT_POWER, '0, '0, 31'd97);
        send_word(ACT_POWER, '0, 63'd5, 31'd97);
        send_word(ACT_POWER, 63'd5, '0, 31'd2);
        send_word(ACT_POWER, '1, '1, 31'h7FFF_FFFF);
        send_word(ACT_POWER, '1, 63'd1, 31'd1000000007);
        send_word(ACT_POWER, 63'd123, 63'd1 << 62, 31'h7FFF_FFFF);
        send_word(ACT_POWER, 63'd7, 63'd10, 31'd0);
        send_word(ACT_POWER, 63'd7, 63'd10, 31'd1);
        send_word(ACT_INVERSE, 63'd7, 63'd10, 31'd0);
        send_word(ACT_INVERSE, 63'd7, 63'd10, 31'd1);
        send_word(ACT_INVERSE, '1, '0, 31'd2);
        send_word(ACT_INVERSE, 63'd5, '0, 31'd3);
        send_word(ACT_INVERSE, 63'd123456789, '0, 31'd1000000007);
        send_word(ACT_INVERSE, '1, '0, 31'h7FFF_FFFF);
        // A composite modulus and a base that is a multiple of the modulus raise no flag.
        send_word(ACT_INVERSE, 63'd3, '0, 31'd1000000);
        send_word(ACT_INVERSE, 63'd998244353 * 5, '0, 31'd998244353);
        send_word(ACT_POWER, 63'd2147483646, 63'd2, 31'h7FFF_FFFF);
        send_word(ACT_POWER, 63'h2AAA_AAAA_AAAA_AAAA, 63'h5555_5555_5555_5555,
                  31'h2AAA_AAAA);
        send_word(ACT_POWER, 63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA,
                  31'h5555_5555);
        send_word(ACT_INVERSE, 63'd2, '1, 31'd65537);
        send_word(ACT_POWER, 63'd1 << 62, 63'd3, 31'h7FFF_FFFE);
    endtask

    // The sink holds its stall for a long stretch while words keep coming, so the
    // output register fills and the input side has to stall.
    task automatic test_output_backpressure();
        idle_enable = 1'b0;
        hold_request = LONG_HOLD;
        repeat (5) send_random_word();
        idle_enable = 1'b1;
    endtask

    task automatic test_random_with_gaps(input int unsigned count);
        repeat (count) send_random_word();
    endtask

    task automatic test_random_back_to_back(input int unsigned count);
        idle_enable = 1'b0;
        repeat (count) send_random_word();
        idle_enable = 1'b1;
    endtask

    initial begin : output_sink
        int unsigned hold;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_request != 0) begin
                hold = hold_request;
                hold_request = 0;
            end else if (idle_enable) begin
                hold = $urandom_range(0, MAX_GAP);
            end else begin
                hold = 0;
            end
            if (hold != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
        end
    end

    always @(posedge i_clk) begin : check_results
        t_pending want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_powers.size() == 0) begin
                report_mismatch("with no word pending", words_sent, o_result, '0);
            end else begin
                want = pending_powers.pop_front();
                if (o_result !== want.power) begin
                    report_mismatch("result", want.seq, o_result, want.power);
                end
            end
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        wait_drained();
        test_output_backpressure();
        wait_drained();
        test_random_with_gaps(200);
        test_random_back_to_back(65);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("** modular_exponentiation_unit: PASSED **");
        end else begin
            $display("** modular_exponentiation_unit: FAILED **");
        end
        $finish;
    end

    initial begin
        #30_000_000;
        $display("[%0t] timeout, %0d words still pending", $time, pending_powers.size());
        $display("** modular_exponentiation_unit: FAILED **");
        $finish;
    end

endmodule

// File: files.f
sv/mexp_pkg.sv
sv/mexp_ctrl.sv
sv/mexp_dpath.sv
sv/modular_exponentiation_unit.sv
sv/mexp_checker.sv
dv/tb_top.sv
